>>> sv/qme3d_pkg.sv
// Shared types, widths and helper functions for the 3D quantizer and Morton encoder.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none
package qme3d_pkg;
    localparam int POS_WIDTH  = 64;
    localparam int COORD_BITS = 21;
    localparam int CELL_WIDTH = 63;
    localparam int CODE_WIDTH = 63;
    localparam int LATENCY    = POS_WIDTH + 2;

    typedef struct packed {
        logic signed [POS_WIDTH-1:0] pos_x;
        logic signed [POS_WIDTH-1:0] pos_y;
        logic signed [POS_WIDTH-1:0] pos_z;
        logic                        last_in;
    } t_in_word;

    typedef struct packed {
        logic [CODE_WIDTH-1:0] morton_code;
        logic                  last_out;
    } t_out_word;

    typedef struct packed {
        logic                  valid;
        logic                  tag;
        logic [COORD_BITS-1:0] coord;
    } t_lane_res;

    function automatic logic [CODE_WIDTH-1:0] spread3(input logic [COORD_BITS-1:0] v);
        logic [CODE_WIDTH-1:0] s;
        s = '0;
        for (int i = 0; i < COORD_BITS; i++) begin
            s[3*i] = v[i];
        end
        return s;
    endfunction
endpackage
`default_nettype wire

>>> sv/qme3d_lane.sv
// One coordinate lane: pipelined restoring divider with one quotient bit per stage.
// Depends on qme3d_pkg for widths and the lane result struct.
`default_nettype none
module qme3d_lane (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_valid,
    input  wire logic                                  i_tag,
    input  wire logic signed [qme3d_pkg::POS_WIDTH-1:0] i_pos,
    input  wire logic [qme3d_pkg::CELL_WIDTH-1:0]      i_div,
    output qme3d_pkg::t_lane_res                       o_res
);
    localparam int W = qme3d_pkg::POS_WIDTH;
    localparam int D = qme3d_pkg::CELL_WIDTH;
    localparam int Q = qme3d_pkg::COORD_BITS;

    logic [D-1:0] r_rem [0:W];
    logic [W-1:0] r_num [0:W];
    logic [Q-1:0] r_q   [0:W];
    logic         r_neg [0:W];
    logic         r_tag [0:W];
    logic         r_v   [0:W];
    logic [D-1:0] n_rem [0:W-1];
    logic [Q-1:0] n_q   [0:W-1];
    logic [W-1:0] mag;
    logic [Q-1:0] qf;

    assign mag = i_pos[W-1] ? (~i_pos + 1'b1) : i_pos;

    always_comb begin
        logic [W-1:0] trial;
        logic         ge;
        for (int i = 0; i < W; i++) begin
            trial    = {r_rem[i], r_num[i][W-1]};
            ge       = trial >= {1'b0, i_div};
            n_rem[i] = ge ? D'(trial - {1'b0, i_div}) : trial[D-1:0];
            n_q[i]   = {r_q[i][Q-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0] <= '0;
        r_num[0] <= mag;
        r_q[0]   <= '0;
        r_neg[0] <= i_pos[W-1];
        r_tag[0] <= i_tag;
        for (int i = 0; i < W; i++) begin
            r_rem[i+1] <= n_rem[i];
            r_num[i+1] <= r_num[i] << 1;
            r_q[i+1]   <= n_q[i];
            r_neg[i+1] <= r_neg[i];
            r_tag[i+1] <= r_tag[i];
        end
        if (!i_rst_n) begin
            for (int i = 0; i <= W; i++) begin
                r_v[i] <= 1'b0;
            end
        end else begin
            r_v[0] <= i_valid;
            for (int i = 0; i < W; i++) begin
                r_v[i+1] <= r_v[i];
            end
        end
    end

    assign qf          = r_neg[W] ? (~r_q[W] + 1'b1) : r_q[W];
    assign o_res.valid = r_v[W];
    assign o_res.tag   = r_tag[W];
    assign o_res.coord = qf;
endmodule
`default_nettype wire

>>> sv/qme3d_merge.sv
// Merging stage: interleaves the three lane coordinates into the registered Morton code.
// Depends on qme3d_pkg for the lane result struct, output word and spread function.
`default_nettype none
module qme3d_merge (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire qme3d_pkg::t_lane_res i_x,
    input  wire qme3d_pkg::t_lane_res i_y,
    input  wire qme3d_pkg::t_lane_res i_z,
    output logic                      o_done,
    output qme3d_pkg::t_out_word      o_data
);
    logic                 r_done;
    qme3d_pkg::t_out_word r_data;

    always_ff @(posedge i_clk) begin
        r_data.morton_code <= qme3d_pkg::spread3(i_x.coord)
                            | (qme3d_pkg::spread3(i_y.coord) << 1)
                            | (qme3d_pkg::spread3(i_z.coord) << 2);
        r_data.last_out    <= i_x.tag;
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_x.valid & i_y.valid & i_z.valid;
        end
    end

    assign o_done = r_done;
    assign o_data = r_data;
endmodule
`default_nettype wire

>>> sv/quantize_morton_encode_3d.sv
// Top level of the 3D position quantizer and Morton encoder.
// Depends on qme3d_pkg, qme3d_lane and qme3d_merge.
//
// A new word is taken every cycle; busy is never raised. Each word comes out on
// o_data with o_done high for one cycle, after passing through one input stage,
// 64 divider stages (one quotient bit each) per coordinate lane, and the merge
// register. The receiver cannot stall the block. The cell size register may only
// be written while no word is in flight.
`default_nettype none
module quantize_morton_encode_3d (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire qme3d_pkg::t_in_word               i_data,
    output logic                                   o_done,
    output qme3d_pkg::t_out_word                   o_data,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [qme3d_pkg::CELL_WIDTH-1:0]  i_cfg_data
);
    logic [qme3d_pkg::CELL_WIDTH-1:0] r_cell;
    logic [qme3d_pkg::CELL_WIDTH-1:0] div;
    qme3d_pkg::t_lane_res             res_x, res_y, res_z;
    logic                             acc;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign acc         = start & ~busy;
    assign div         = (r_cell == '0) ? qme3d_pkg::CELL_WIDTH'(1) : r_cell;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell <= qme3d_pkg::CELL_WIDTH'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_cell <= i_cfg_data;
        end
    end

    qme3d_lane u_lane_x (.i_clk, .i_rst_n, .i_valid(acc), .i_tag(i_data.last_in),
                         .i_pos(i_data.pos_x), .i_div(div), .o_res(res_x));
    qme3d_lane u_lane_y (.i_clk, .i_rst_n, .i_valid(acc), .i_tag(i_data.last_in),
                         .i_pos(i_data.pos_y), .i_div(div), .o_res(res_y));
    qme3d_lane u_lane_z (.i_clk, .i_rst_n, .i_valid(acc), .i_tag(i_data.last_in),
                         .i_pos(i_data.pos_z), .i_div(div), .o_res(res_z));

    qme3d_merge u_merge (.i_clk, .i_rst_n, .i_x(res_x), .i_y(res_y), .i_z(res_z),
                         .o_done, .o_data);
endmodule
`default_nettype wire

>>> sv/qme3d_checker.sv
// Port-level checks for the quantizer and Morton encoder, bound to the top level.
// Depends on qme3d_pkg for the pipeline latency and the port types.
`default_nettype none
module qme3d_checker (
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 start,
    input wire logic                 busy,
    input wire logic                 o_done,
    input wire logic                 o_cfg_ready,
    input wire qme3d_pkg::t_in_word  i_data,
    input wire qme3d_pkg::t_out_word o_data
);
    localparam int L = qme3d_pkg::LATENCY;

    a_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n) !busy && o_cfg_ready)
        else $error("block stalled an input or configuration word");
    a_done_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start, L))
        else $error("result word without a matching input word");
    a_done_dst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##L o_done)
        else $error("input word produced no result word");
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_data.last_out == $past(i_data.last_in, L)))
        else $error("last flag not carried through");
endmodule

bind quantize_morton_encode_3d qme3d_checker u_checker (
    .i_clk, .i_rst_n, .start, .busy, .o_done, .o_cfg_ready, .i_data, .o_data
);
`default_nettype wire

>>> tb/quantize_morton_encode_3d_test.sv
// Testbench for the 3D quantizer and Morton encoder: random and directed words
// checked against an in-bench predictor. Depends on qme3d_pkg and the DUT.
`timescale 1ns / 1ps
module quantize_morton_encode_3d_test;
    localparam int MAX_CYCLES = 400000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    qme3d_pkg::t_in_word  i_data = '0;
    logic                 o_done;
    qme3d_pkg::t_out_word o_data;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [qme3d_pkg::CELL_WIDTH-1:0] i_cfg_data = '0;

    logic [qme3d_pkg::CELL_WIDTH-1:0] cell_div = qme3d_pkg::CELL_WIDTH'(1);
    qme3d_pkg::t_out_word code_q[$];
    int                   mismatches = 0;
    int                   words_sent = 0;
    int                   codes_seen = 0;
    int                   cycles = 0;
    int                   idle_pct = 0;

    quantize_morton_encode_3d DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_data(i_data), .o_done(o_done), .o_data(o_data),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic logic [qme3d_pkg::COORD_BITS-1:0] grid_index(
            logic [qme3d_pkg::POS_WIDTH-1:0] raw);
        logic [63:0] mag;
        logic [63:0] q;
        logic [63:0] d;
        d = (cell_div == 0) ? 64'd1 : {1'b0, cell_div};
        mag = raw[63] ? (64'd0 - raw) : raw;
        q = mag / d;
        if (raw[63]) begin
            q = 64'd0 - q;
        end
        return q[qme3d_pkg::COORD_BITS-1:0];
    endfunction

    function automatic qme3d_pkg::t_out_word predict_code(qme3d_pkg::t_in_word w);
        qme3d_pkg::t_out_word r;
        logic [qme3d_pkg::COORD_BITS-1:0] gx, gy, gz;
        gx = grid_index(w.pos_x);
        gy = grid_index(w.pos_y);
        gz = grid_index(w.pos_z);
        r.morton_code = '0;
        for (int i = 0; i < qme3d_pkg::COORD_BITS; i++) begin
            r.morton_code[3*i]   = gx[i];
            r.morton_code[3*i+1] = gy[i];
            r.morton_code[3*i+2] = gz[i];
        end
        r.last_out = w.last_in;
        return r;
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLES) begin
            $display("Timeout after %0d cycles.", cycles);
            $display("== FAIL ==");
            $finish;
        end
        if (i_rst_n && o_done) begin
            codes_seen <= codes_seen + 1;
            if (code_q.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10) $display("Unexpected word %h.", o_data);
            end else begin
                if (o_data.morton_code !== code_q[0].morton_code ||
                        o_data.last_out !== code_q[0].last_out) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10) begin
                        $display("Mismatch: expected code %h last %b, got code %h last %b.",
                                 code_q[0].morton_code, code_q[0].last_out,
                                 o_data.morton_code, o_data.last_out);
                    end
                end
                void'(code_q.pop_front());
            end
        end
    end

    task automatic send_position(qme3d_pkg::t_in_word w);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_data <= w;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        code_q.push_back(predict_code(w));
        words_sent++;
    endtask

    task automatic drain;
        start <= 1'b0;
        while (code_q.size() != 0) @(posedge i_clk);
        repeat (qme3d_pkg::LATENCY + 10) @(posedge i_clk);
    endtask

    task automatic write_cell_size(logic [qme3d_pkg::CELL_WIDTH-1:0] v);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        cell_div = v;
    endtask

    function automatic logic [63:0] rand64();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(5))
            0: v = {{44{v[63]}}, v[19:0]};
            1: v = {{32{v[63]}}, v[31:0]};
            default: ;
        endcase
        return v;
    endfunction

    function automatic qme3d_pkg::t_in_word random_position();
        qme3d_pkg::t_in_word w;
        w.pos_x = rand64();
        w.pos_y = rand64();
        w.pos_z = rand64();
        w.last_in = $urandom_range(1);
        return w;
    endfunction

    task automatic test_extremes;
        logic [63:0] vals[6];
        qme3d_pkg::t_in_word w;
        vals = '{64'h8000_0000_0000_0000, 64'h7fff_ffff_ffff_ffff, 64'd0,
                 64'hffff_ffff_ffff_ffff, 64'd1, 64'h0000_0000_001f_ffff};
        idle_pct = 0;
        foreach (vals[i]) begin
            w.pos_x = vals[i];
            w.pos_y = vals[(i + 1) % 6];
            w.pos_z = vals[(i + 2) % 6];
            w.last_in = i[0];
            send_position(w);
        end
    endtask

    task automatic test_cell_sizes;
        logic [qme3d_pkg::CELL_WIDTH-1:0] sizes[5];
        sizes = '{63'd0, {qme3d_pkg::CELL_WIDTH{1'b1}}, 63'd3, 63'h1_0000, 63'd1};
        foreach (sizes[i]) begin
            write_cell_size(sizes[i]);
            test_extremes();
            repeat (2) send_position(random_position());
        end
    endtask

    task automatic test_random(int pct, int n);
        idle_pct = pct;
        for (int i = 0; i < n; i++) begin
            send_position(random_position());
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes();
        test_cell_sizes();
        test_random(0, 300);
        write_cell_size(63'd7);
        test_random(84, 200);
        write_cell_size({1'b0, $urandom} + 63'd1);
        test_random(26, 250);
        write_cell_size(63'h40_0000_0000);
        test_random(0, 300);
        drain();
        $display("Sent %0d positions over several cell sizes and idle rates; %0d codes checked.",
                 words_sent, codes_seen);
        if (mismatches == 0 && code_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches.", mismatches);
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
